// File: hw/rtl/vrw_pkg.sv
`timescale 1ns / 1ps
package vrw_pkg;

    localparam int SEQ_REGS        = 5;
    localparam int CRTC_REGS       = 25;
    localparam int GFX_REGS        = 9;
    localparam int ATTR_REGS       = 21;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int PAL_DW          = 18;

    typedef enum logic [3:0] {
        PORT_MISC      = 4'd0,
        PORT_FEATURE   = 4'd1,
        PORT_SEQ_IDX   = 4'd2,
        PORT_SEQ_DATA  = 4'd3,
        PORT_CRTC_IDX  = 4'd4,
        PORT_CRTC_DATA = 4'd5,
        PORT_GFX_IDX   = 4'd6,
        PORT_GFX_DATA  = 4'd7,
        PORT_ATTR      = 4'd8,
        PORT_DAC_RIDX  = 4'd9,
        PORT_DAC_WIDX  = 4'd10,
        PORT_DAC_DATA  = 4'd11
    } t_port;

    typedef enum logic [2:0] {
        BANK_NONE = 3'd0,
        BANK_MISC = 3'd1,
        BANK_SEQ  = 3'd2,
        BANK_CRTC = 3'd3,
        BANK_GFX  = 3'd4,
        BANK_ATTR = 3'd5,
        BANK_DAC  = 3'd6
    } t_bank;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
        logic [PAL_DW-1:0] data;
    } t_pal_wr;

endpackage

// File: hw/rtl/vga_register_write_decoder.sv
`timescale 1ns / 1ps
// channel | valid   | ready   | fields
// in      | i_valid | o_ready | i_mode, i_data
// out     | o_valid | i_ready | o_bank .. o_attribute_control
// Each word is handled in an accept step (palette read issued), then an
// execute step (palette written back, result loaded). The palette port's
// registered read sets this. A new word is taken in the cycle the result leaves.
// Synchronous active-low reset; palette reads as zero until written.
// Decoded outputs hold steady while a result waits.
module vga_register_write_decoder
    import vrw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_mode,
    input  logic [7:0]  i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_bank,
    output logic [7:0]  o_reg_index,
    output logic [23:0] o_stored_value,
    output logic [11:0] o_screen_width,
    output logic [8:0]  o_screen_height,
    output logic [5:0]  o_char_height,
    output logic [15:0] o_start_address,
    output logic [7:0]  o_display_pitch,
    output logic [1:0]  o_memory_map,
    output logic [35:0] o_plane_control,
    output logic [8:0]  o_display_control,
    output logic [10:0] o_attribute_control
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_port  r_mode;
    logic [7:0] r_data;
    logic [2:0] r_bank, n_bank;
    logic [7:0] r_idx, n_idx;
    logic [23:0] r_val, n_val;

    logic [7:0] r_seq_index, n_seq_index, r_crtc_index, n_crtc_index;
    logic [7:0] r_gfx_index, n_gfx_index, r_attr_index, n_attr_index;
    logic       r_attr_phase, n_attr_phase;
    logic [7:0] r_dac_index, n_dac_index;
    logic [1:0] r_dac_comp, n_dac_comp;
    logic [8:0] r_cpl, n_cpl;
    logic       r_cw9, n_cw9;
    logic [8:0] r_height, n_height;
    logic [5:0] r_char_h, n_char_h;
    logic [15:0] r_start, n_start;
    logic [7:0] r_pitch, n_pitch;
    logic [1:0] r_mmap, n_mmap;
    logic [35:0] r_pc, n_pc;
    logic [7:0] r_dc, n_dc;
    logic [10:0] r_ac, n_ac;

    logic              accept;
    logic [PAL_DW-1:0] pal_rd;
    t_pal_wr           pal_wr;
    logic [11:0]       cpl_x8;

    assign o_ready = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign accept  = i_valid && o_ready;

    vrw_palette u_palette (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (r_dac_index),
        .i_wr      (pal_wr),
        .o_rd_data (pal_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_seq_index  <= '0;
            r_crtc_index <= '0;
            r_gfx_index  <= '0;
            r_attr_index <= '0;
            r_attr_phase <= 1'b0;
            r_dac_index  <= '0;
            r_dac_comp   <= '0;
            r_cpl        <= 9'd80;
            r_cw9        <= 1'b1;
            r_height     <= 9'd400;
            r_char_h     <= 6'd16;
            r_start      <= '0;
            r_pitch      <= '0;
            r_mmap       <= '0;
            r_pc         <= '0;
            r_dc         <= '0;
            r_ac         <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_seq_index  <= n_seq_index;
            r_crtc_index <= n_crtc_index;
            r_gfx_index  <= n_gfx_index;
            r_attr_index <= n_attr_index;
            r_attr_phase <= n_attr_phase;
            r_dac_index  <= n_dac_index;
            r_dac_comp   <= n_dac_comp;
            r_cpl        <= n_cpl;
            r_cw9        <= n_cw9;
            r_height     <= n_height;
            r_char_h     <= n_char_h;
            r_start      <= n_start;
            r_pitch      <= n_pitch;
            r_mmap       <= n_mmap;
            r_pc         <= n_pc;
            r_dc         <= n_dc;
            r_ac         <= n_ac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= t_port'(i_mode);
            r_data <= i_data;
        end
        r_bank <= n_bank;
        r_idx  <= n_idx;
        r_val  <= n_val;
    end

    always_comb begin
        logic [5:0]  c;
        logic [17:0] e;
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_bank       = r_bank;
        n_idx        = r_idx;
        n_val        = r_val;
        n_seq_index  = r_seq_index;
        n_crtc_index = r_crtc_index;
        n_gfx_index  = r_gfx_index;
        n_attr_index = r_attr_index;
        n_attr_phase = r_attr_phase;
        n_dac_index  = r_dac_index;
        n_dac_comp   = r_dac_comp;
        n_cpl        = r_cpl;
        n_cw9        = r_cw9;
        n_height     = r_height;
        n_char_h     = r_char_h;
        n_start      = r_start;
        n_pitch      = r_pitch;
        n_mmap       = r_mmap;
        n_pc         = r_pc;
        n_dc         = r_dc;
        n_ac         = r_ac;
        pal_wr       = '0;
        c            = r_data[5:0];
        e            = pal_rd;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_bank      = BANK_NONE;
                n_idx       = '0;
                n_val       = '0;
                case (r_mode)
                    PORT_MISC: begin
                        n_bank   = BANK_MISC;
                        n_val    = {16'd0, r_data};
                        n_height = (r_data[7:6] == 2'b10) ? 9'd350 :
                                   (r_data[7:6] == 2'b11) ? 9'd480 : 9'd400;
                    end
                    PORT_SEQ_IDX:  n_seq_index  = r_data;
                    PORT_CRTC_IDX: n_crtc_index = r_data;
                    PORT_GFX_IDX:  n_gfx_index  = r_data;
                    PORT_SEQ_DATA: begin
                        n_bank = BANK_SEQ;
                        n_idx  = r_seq_index;
                        if ({1'b0, r_seq_index} < 9'(SEQ_REGS)) n_val = {16'd0, r_data};
                        if (r_seq_index == 8'd1) n_cw9 = ~r_data[0];
                        if (r_seq_index == 8'd2) n_dc[3:0] = r_data[3:0];
                        if (r_seq_index == 8'd4) begin
                            n_dc[4] = r_data[3];
                            n_dc[5] = ~r_data[2];
                        end
                    end
                    PORT_CRTC_DATA: begin
                        n_bank = BANK_CRTC;
                        n_idx  = r_crtc_index;
                        if ({1'b0, r_crtc_index} < 9'(CRTC_REGS)) n_val = {16'd0, r_data};
                        if (r_crtc_index == 8'h01) n_cpl = {1'b0, r_data} + 9'd1;
                        if (r_crtc_index == 8'h09) begin
                            n_char_h = {1'b0, r_data[4:0]} + 6'd1;
                            n_dc[7]  = r_data[7];
                        end
                        if (r_crtc_index == 8'h0c) n_start[15:8] = r_data;
                        if (r_crtc_index == 8'h0d) n_start[7:0]  = r_data;
                        if (r_crtc_index == 8'h13) n_pitch       = r_data;
                    end
                    PORT_GFX_DATA: begin
                        n_bank = BANK_GFX;
                        n_idx  = r_gfx_index;
                        if ({1'b0, r_gfx_index} < 9'(GFX_REGS)) n_val = {16'd0, r_data};
                        case (r_gfx_index)
                            8'd0: n_pc[3:0]   = r_data[3:0];
                            8'd1: n_pc[7:4]   = r_data[3:0];
                            8'd2: n_pc[11:8]  = r_data[3:0];
                            8'd3: begin
                                n_pc[14:12] = r_data[2:0];
                                n_pc[16:15] = r_data[4:3];
                            end
                            8'd4: n_pc[18:17] = r_data[1:0];
                            8'd5: begin
                                n_pc[20:19] = r_data[1:0];
                                n_pc[21]    = r_data[3];
                                n_pc[23:22] = r_data[6:5];
                            end
                            8'd6: begin
                                n_mmap  = r_data[3:2];
                                n_dc[6] = r_data[0];
                            end
                            8'd7: n_pc[27:24] = r_data[3:0];
                            8'd8: n_pc[35:28] = r_data;
                            default: ;
                        endcase
                    end
                    PORT_ATTR: begin
                        n_attr_phase = ~r_attr_phase;
                        if (!r_attr_phase) begin
                            n_attr_index = r_data;
                        end else begin
                            n_bank = BANK_ATTR;
                            n_idx  = r_attr_index;
                            if ({1'b0, r_attr_index} < 9'(ATTR_REGS)) begin
                                n_val = (r_attr_index < 8'h10) ? {18'd0, r_data[5:0]}
                                                               : {16'd0, r_data};
                            end
                            if (r_attr_index == 8'h10) begin
                                n_ac[0] = r_data[2];
                                n_ac[1] = r_data[3];
                                n_ac[2] = r_data[7];
                            end
                            if (r_attr_index == 8'h12) n_ac[6:3] = r_data[3:0];
                            if (r_attr_index == 8'h14) begin
                                n_ac[8:7]  = r_data[3:2];
                                n_ac[10:9] = r_data[1:0];
                            end
                        end
                    end
                    PORT_DAC_RIDX, PORT_DAC_WIDX: begin
                        n_dac_index = r_data;
                        n_dac_comp  = '0;
                    end
                    PORT_DAC_DATA: begin
                        // word layout {r, g, b}; read issued at accept
                        case (r_dac_comp)
                            2'd0:    e[17:12] = c;
                            2'd1:    e[11:6]  = c;
                            default: e[5:0]   = c;
                        endcase
                        pal_wr.en   = 1'b1;
                        pal_wr.addr = r_dac_index;
                        pal_wr.data = e;
                        n_bank      = BANK_DAC;
                        n_idx       = r_dac_index;
                        n_val       = {e[17:12], 2'b00, e[11:6], 2'b00, e[5:0], 2'b00};
                        if (r_dac_comp >= 2'd2) begin
                            n_dac_comp  = '0;
                            n_dac_index = r_dac_index + 8'd1;
                        end else begin
                            n_dac_comp = r_dac_comp + 2'd1;
                        end
                    end
                    default: ;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign cpl_x8 = {r_cpl, 3'b000};

    assign o_valid             = r_out_valid;
    assign o_bank              = r_bank;
    assign o_reg_index         = r_idx;
    assign o_stored_value      = r_val;
    assign o_screen_width      = r_cw9 ? (cpl_x8 + {3'd0, r_cpl}) : cpl_x8;
    assign o_screen_height     = r_height;
    assign o_char_height       = r_char_h;
    assign o_start_address     = r_start;
    assign o_display_pitch     = r_pitch;
    assign o_memory_map        = r_mmap;
    assign o_plane_control     = r_pc;
    assign o_display_control   = {~r_cw9, r_dc};
    assign o_attribute_control = r_ac;

`ifndef ASSERT_OFF
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted word did not enter execute");
    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EXEC))
        else $error("result raised outside execute");
    a_pal_wr_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pal_wr.en |-> (r_state == S_EXEC && r_mode == PORT_DAC_DATA))
        else $error("palette written outside dac data execute");
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !accept)
        else $error("word accepted while result stalled");
`endif

endmodule

// File: hw/rtl/vrw_palette.sv
`timescale 1ns / 1ps
module vrw_palette
    import vrw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [PAL_AW-1:0] i_rd_addr,
    input  t_pal_wr           i_wr,
    output logic [PAL_DW-1:0] o_rd_data
);

    logic [PAL_DW-1:0]          r_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_vld;
    logic [PAL_DW-1:0]          r_rd_data;
    logic                       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
